[hdl/mwc_pkg.sv]
package mwc_pkg;

  // op codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_SEED   = 2'd0,
    OP_RAW    = 2'd1,
    OP_RANGED = 2'd2,
    OP_GAUSS  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MDIV,
    ST_DDIV,
    ST_MUL,
    ST_ADD,
    ST_DRAWN,
    ST_QDIV,
    ST_FIN
  } state_e;

  localparam int unsigned DataW   = 32;
  localparam int unsigned DivW    = DataW + 1;  // divisor may reach 2^32
  localparam int unsigned DigitW  = 16;
  localparam int unsigned SeedTriesW = 20;      // seed loop gives up after 2^20 draws

  localparam logic [DigitW-1:0] MulZ = 16'd36969;
  localparam logic [DigitW-1:0] MulW = 16'd18000;

  localparam logic [DataW-1:0] SeedOfs  = 32'h1111_1111;
  localparam logic [DataW-1:0] ZReset   = 32'hBEEF_DEAD;
  localparam logic [DataW-1:0] WReset   = 32'hDEAD_BEEF;
  localparam logic [DataW-1:0] AllOnes  = 32'hFFFF_FFFF;
  localparam logic [DivW-1:0]  GaussDiv = 33'd6;
  localparam logic [2:0]       GaussDraws = 3'd6;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DivW-1:0]  divisor;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[hdl/mwc_random_generator_unit.sv]
// Steps, accept to result valid: raw takes one draw, seed draws again on each zero draw,
// ranged one divide and one draw+divide round (a zero limit goes straight to the post), gaussian
// (a limit below six stops after its first divide): two divides, six draw+divide rounds, then the post.
// One transaction in flight; the next is accepted the cycle after the result is posted, even
// while that result still waits in the output register (a new result holds until it drains).
// Reset (async, active low) loads w = 0xDEADBEEF, z = 0xBEEFDEAD and empties the output.
module mwc_random_generator_unit
  import mwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [31:0] stored_word, [63:32] fallback_seed, [95:64] limit
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] number
  output logic        m_axis_tuser    // [0] bad_limit
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  op_e    in_op;

  logic [DataW-1:0]    in_stored, in_fallback, in_limit;

  // generator halves
  logic [DataW-1:0]    w_half_q, w_half_d;
  logic [DataW-1:0]    z_half_q, z_half_d;

  // bit-serial multiplier: accumulators and shifting low digits
  logic [DataW-1:0]    mz_q, mz_d;
  logic [DataW-1:0]    mw_q, mw_d;
  logic [DigitW-1:0]   zlo_q, zlo_d;
  logic [DigitW-1:0]   wlo_q, wlo_d;
  logic [3:0]          bit_cnt_q, bit_cnt_d;

  logic [DivW-1:0]     divisor_q, divisor_d;
  logic [DataW-1:0]    acc_q, acc_d;
  logic                bad_q, bad_d;
  logic [2:0]          rounds_q, rounds_d;
  logic [SeedTriesW:0] tries_q, tries_d;

  logic                out_valid_q, out_valid_d;
  logic [DataW-1:0]    out_data_q, out_data_d;
  logic                out_bad_q, out_bad_d;

  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [DataW-1:0]    div_quo;

  logic [DataW-1:0]    w_seed, z_sum, z_seed;
  logic [DataW-1:0]    draw_w;

  assign in_stored   = s_axis_tdata[31:0];
  assign in_fallback = s_axis_tdata[63:32];
  assign in_limit    = s_axis_tdata[95:64];
  assign in_op       = op_e'(s_axis_tuser);

  // seed: all-ones stored word means unwritten, take the fallback
  assign w_seed = (in_stored == AllOnes) ? in_fallback : in_stored;
  assign z_sum  = ~w_seed + SeedOfs;
  assign z_seed = (z_sum == '0) ? ZReset : z_sum;

  // (z << 16) + w, only the upper digit needs an add
  assign draw_w = {z_half_q[DigitW-1:0] + w_half_q[DataW-1:DigitW], w_half_q[DigitW-1:0]};

  assign s_axis_tready = (state_q == ST_IDLE);

  mwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    w_half_d    = w_half_q;
    z_half_d    = z_half_q;
    mz_d        = mz_q;
    mw_d        = mw_q;
    zlo_d       = zlo_q;
    wlo_d       = wlo_q;
    bit_cnt_d   = bit_cnt_q;
    divisor_d   = divisor_q;
    acc_d       = acc_q;
    bad_d       = bad_q;
    rounds_d    = rounds_q;
    tries_d     = tries_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_bad_d   = out_bad_q;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = draw_w;
    div_ctl.divisor  = divisor_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d      = in_op;
          acc_d     = '0;
          bad_d     = 1'b0;
          tries_d   = '0;
          bit_cnt_d = '0;
          mz_d      = '0;
          mw_d      = '0;
          zlo_d     = z_half_q[DigitW-1:0];
          wlo_d     = w_half_q[DigitW-1:0];
          case (in_op)
            OP_SEED: begin
              w_half_d = w_seed;
              z_half_d = z_seed;
              zlo_d    = z_seed[DigitW-1:0];
              wlo_d    = w_seed[DigitW-1:0];
              state_d  = ST_MUL;
            end
            OP_RAW: begin
              state_d = ST_MUL;
            end
            OP_RANGED: begin
              if (in_limit == '0) begin
                bad_d   = 1'b1;
                state_d = ST_FIN;
              end else begin
                rounds_d         = 3'd1;
                div_ctl.start    = 1'b1;
                div_ctl.dividend = AllOnes;
                div_ctl.divisor  = {1'b0, in_limit};
                state_d          = ST_DDIV;
              end
            end
            OP_GAUSS: begin
              rounds_d         = GaussDraws;
              div_ctl.start    = 1'b1;
              div_ctl.dividend = in_limit;
              div_ctl.divisor  = GaussDiv;
              state_d          = ST_MDIV;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // effective gaussian bound = limit / 6
      ST_MDIV: begin
        if (div_sts.done) begin
          if (div_quo == '0) begin
            bad_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            div_ctl.start    = 1'b1;
            div_ctl.dividend = AllOnes;
            div_ctl.divisor  = {1'b0, div_quo};
            state_d          = ST_DDIV;
          end
        end
      end

      // scale divisor = 0xFFFFFFFF / bound + 1, kept in 33 bits
      ST_DDIV: begin
        if (div_sts.done) begin
          divisor_d = {1'b0, div_quo} + DivW'(1);
          mz_d      = '0;
          mw_d      = '0;
          zlo_d     = z_half_q[DigitW-1:0];
          wlo_d     = w_half_q[DigitW-1:0];
          bit_cnt_d = '0;
          state_d   = ST_MUL;
        end
      end

      // one multiplier bit per cycle, MSB first
      ST_MUL: begin
        mz_d      = {mz_q[DataW-2:0], 1'b0} + (zlo_q[DigitW-1] ? {16'b0, MulZ} : '0);
        mw_d      = {mw_q[DataW-2:0], 1'b0} + (wlo_q[DigitW-1] ? {16'b0, MulW} : '0);
        zlo_d     = {zlo_q[DigitW-2:0], 1'b0};
        wlo_d     = {wlo_q[DigitW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 4'd1;
        if (bit_cnt_q == 4'd15) begin
          state_d = ST_ADD;
        end
      end

      // add the carry digit (upper half)
      ST_ADD: begin
        z_half_d = mz_q + {16'b0, z_half_q[DataW-1:DigitW]};
        w_half_d = mw_q + {16'b0, w_half_q[DataW-1:DigitW]};
        state_d  = ST_DRAWN;
      end

      ST_DRAWN: begin
        mz_d      = '0;
        mw_d      = '0;
        zlo_d     = z_half_q[DigitW-1:0];
        wlo_d     = w_half_q[DigitW-1:0];
        bit_cnt_d = '0;
        case (op_q)
          OP_SEED: begin
            tries_d = tries_q + (SeedTriesW+1)'(1);
            if (draw_w != '0 || tries_d[SeedTriesW]) begin
              acc_d   = draw_w;
              state_d = ST_FIN;
            end else begin
              state_d = ST_MUL;
            end
          end
          OP_RAW: begin
            acc_d   = draw_w;
            state_d = ST_FIN;
          end
          default: begin
            div_ctl.start    = 1'b1;
            div_ctl.dividend = draw_w;
            div_ctl.divisor  = divisor_q;
            state_d          = ST_QDIV;
          end
        endcase
      end

      ST_QDIV: begin
        if (div_sts.done) begin
          acc_d    = acc_q + div_quo;
          rounds_d = rounds_q - 3'd1;
          if (rounds_q == 3'd1) begin
            state_d = ST_FIN;
          end else begin
            mz_d      = '0;
            mw_d      = '0;
            zlo_d     = z_half_q[DigitW-1:0];
            wlo_d     = w_half_q[DigitW-1:0];
            bit_cnt_d = '0;
            state_d   = ST_MUL;
          end
        end
      end

      // post result once the output register is free
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SEED;
      w_half_q    <= WReset;
      z_half_q    <= ZReset;
      bit_cnt_q   <= '0;
      rounds_q    <= '0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      w_half_q    <= w_half_d;
      z_half_q    <= z_half_d;
      bit_cnt_q   <= bit_cnt_d;
      rounds_q    <= rounds_d;
      tries_q     <= tries_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mz_q       <= mz_d;
    mw_q       <= mw_d;
    zlo_q      <= zlo_d;
    wlo_q      <= wlo_d;
    divisor_q  <= divisor_d;
    acc_q      <= acc_d;
    bad_q      <= bad_d;
    out_data_q <= out_data_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_bad_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("bad_limit with nonzero number");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_fin_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && (!out_valid_q || m_axis_tready) |=> out_valid_q)
    else $error("finished result not posted");

  a_z_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    z_half_q != '0)
    else $error("z half collapsed to zero");

endmodule

[hdl/mwc_div.sv]
// Restoring divider, one quotient bit per cycle.
module mwc_div
  import mwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctl_t         ctl_i,
  output div_sts_t         sts_o,
  output logic [DataW-1:0] quotient_o
);

  logic [DivW-1:0]  rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DivW-1:0]  dvsr_q, dvsr_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DivW:0] trial;
  logic [DivW:0] diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DataW-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign ge    = (trial >= {1'b0, dvsr_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvsr_d = dvsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d  = '0;
      quo_d  = ctl_i.dividend;
      dvsr_d = ctl_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[DataW-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvsr_q <= dvsr_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q)
    else $error("divider did not go busy after start");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(cnt_q) == 5'd31)
    else $error("divider done without a full pass");

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({busy_q, done_q}))
    else $error("divider busy and done together");

endmodule
